FILE: src/mpmm_pkg.sv
package mpmm_pkg;

  typedef enum logic [2:0] {
    FN_CREATE   = 3'd0,
    FN_DESTROY  = 3'd1,
    FN_SEND     = 3'd2,
    FN_TRY_SEND = 3'd3,
    FN_RECEIVE  = 3'd4,
    FN_CFG_IRQ  = 3'd5,
    FN_OWNER    = 3'd6,
    FN_BAD      = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADARG = 3'd1,
    ST_NOPORT = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4,
    ST_NOSLOT = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] port_sel;
    logic [31:0] sender;
    logic [63:0] payload;
    logic [3:0]  length;
    logic [3:0]  capacity;
    logic [31:0] task_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] new_port;
    logic [31:0] sender;
    logic [63:0] data;
    logic [3:0]  length;
    logic [31:0] owner;
  } rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_READ,
    BK_EXEC,
    BK_OUT
  } bk_state_t;

  // Keep the low n bytes of a word
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

FILE: src/mpmm_if.sv
interface mpmm_req_if;
  logic               valid;
  logic               ready;
  mpmm_pkg::req_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mpmm_rsp_if;
  logic               valid;
  logic               ready;
  mpmm_pkg::rsp_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/mpmm_front.sv
module mpmm_front (
  input  logic             clk,
  input  logic             rst_n,
  mpmm_req_if.sink         in_ch,
  output mpmm_pkg::req_t   q_data,
  output logic             q_valid,
  input  logic             q_pop
);
  import mpmm_pkg::*;

  // Two-entry word queue between front and back
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = mem_r[rp_r];

  // Store word as received
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_ch.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2) else $error("queue overrun");

endmodule

FILE: src/mpmm_back.sv
module mpmm_back #(
  parameter int PORTS         = 8,
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mpmm_pkg::req_t   q_data,
  input  logic             q_valid,
  output logic             q_pop,
  mpmm_rsp_if.source       out_ch
);
  import mpmm_pkg::*;

  localparam int SW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MD = PORTS * QUEUE_DEPTH;
  localparam int AW = $clog2(MD);

  // Port table
  logic [PORTS-1:0]  used_r;
  logic [31:0]       port_r  [PORTS];
  logic [31:0]       owner_r [PORTS];
  logic [QW-1:0]     head_r  [PORTS];
  logic [QW-1:0]     tail_r  [PORTS];
  logic [CW-1:0]     count_r [PORTS];
  logic [31:0]       isnd_r  [PORTS];
  logic [3:0]        ilen_r  [PORTS];
  logic [63:0]       idat_r  [PORTS];
  logic [31:0]       icnt_r  [PORTS];
  logic [31:0]       next_id_r;

  // Message store: sender, length, data in one word
  logic [99:0]       msg_mem [MD];
  logic [99:0]       rd_r;

  bk_state_t         st_r, st_nxt;
  req_t              req_r;
  logic              hit_r, free_ok_r;
  logic [SW-1:0]     slot_r;
  rsp_t              rsp_r;
  logic              ov_r;

  logic              hit_c, free_c;
  logic [SW-1:0]     hs_c, fs_c;
  logic              len_bad;
  logic              full_c;
  logic [AW-1:0]     waddr, raddr;
  logic              we;
  rsp_t              rsp_c;
  logic [3:0]        cut;

  // Priority search for match and free slot
  always_comb begin
    hit_c = 1'b0; hs_c = '0; free_c = 1'b0; fs_c = '0;
    for (int i = PORTS - 1; i >= 0; i--) begin
      if (used_r[i] && port_r[i] == req_r.port_sel) begin
        hit_c = 1'b1; hs_c = SW'(i);
      end
      if (!used_r[i]) begin
        free_c = 1'b1; fs_c = SW'(i);
      end
    end
  end

  assign len_bad = (req_r.length == 4'd0) || (req_r.length > 4'(PAYLOAD_BYTES));
  assign full_c  = (count_r[slot_r] >= CW'(QUEUE_DEPTH));
  assign waddr   = AW'(slot_r) * AW'(QUEUE_DEPTH) + AW'(tail_r[slot_r]);
  assign raddr   = AW'(slot_r) * AW'(QUEUE_DEPTH) + AW'(head_r[slot_r]);
  assign we      = (st_r == BK_EXEC) && hit_r && !len_bad && !full_c &&
                   (req_r.func == FN_SEND || req_r.func == FN_TRY_SEND);

  always_ff @(posedge clk) begin
    if (we) msg_mem[waddr] <= {req_r.sender, req_r.length,
                               req_r.payload & byte_mask(req_r.length)};
    if (st_r == BK_READ) rd_r <= msg_mem[raddr];
  end

  // Result of the current word
  always_comb begin
    rsp_c = '0;
    cut   = '0;
    unique case (func_t'(req_r.func))
      FN_CREATE: begin
        if (!free_ok_r) rsp_c.status = ST_NOSLOT;
        else rsp_c.new_port = next_id_r;
      end
      FN_DESTROY: if (!hit_r) rsp_c.status = ST_NOPORT;
      FN_SEND, FN_TRY_SEND: begin
        if (len_bad) rsp_c.status = ST_BADARG;
        else if (!hit_r) rsp_c.status = ST_NOPORT;
        else if (full_c && !(req_r.func == FN_TRY_SEND && ilen_r[slot_r] != 4'd0))
          rsp_c.status = ST_FULL;
      end
      FN_RECEIVE: begin
        if (req_r.capacity == 4'd0) rsp_c.status = ST_BADARG;
        else if (!hit_r) rsp_c.status = ST_NOPORT;
        else if (count_r[slot_r] != '0) begin
          rsp_c.sender = rd_r[99:68];
          rsp_c.length = rd_r[67:64];
          cut = (rd_r[67:64] < req_r.capacity) ? rd_r[67:64] : req_r.capacity;
          rsp_c.data = rd_r[63:0] & byte_mask(cut);
        end else if (ilen_r[slot_r] != 4'd0 && icnt_r[slot_r] != 32'd0) begin
          rsp_c.sender = isnd_r[slot_r];
          rsp_c.length = ilen_r[slot_r];
          cut = (ilen_r[slot_r] < req_r.capacity) ? ilen_r[slot_r] : req_r.capacity;
          rsp_c.data = idat_r[slot_r] & byte_mask(cut);
        end else rsp_c.status = ST_EMPTY;
      end
      FN_CFG_IRQ: begin
        if (len_bad) rsp_c.status = ST_BADARG;
        else if (!hit_r) rsp_c.status = ST_NOPORT;
      end
      FN_OWNER: begin
        if (!hit_r) rsp_c.status = ST_NOPORT;
        else rsp_c.owner = owner_r[slot_r];
      end
      default: rsp_c.status = ST_BADARG;
    endcase
  end

  // Sequencer: lookup, read, execute, deliver
  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    unique case (st_r)
      BK_IDLE: if (q_valid) begin
        q_pop = 1'b1; st_nxt = BK_LOOKUP;
      end
      BK_LOOKUP: st_nxt = BK_READ;
      BK_READ:   st_nxt = BK_EXEC;
      BK_EXEC:   st_nxt = BK_OUT;
      BK_OUT:    if (!ov_r || out_ch.ready) st_nxt = BK_IDLE;
      default:   st_nxt = BK_IDLE;
    endcase
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.payload = rsp_r;

  always_ff @(posedge clk) begin
    if (q_pop) req_r <= q_data;
    if (st_r == BK_LOOKUP) begin
      hit_r <= hit_c; free_ok_r <= free_c;
      slot_r <= (req_r.func == FN_CREATE) ? fs_c : hs_c;
    end
    if (st_r == BK_EXEC) rsp_r <= rsp_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_IDLE;
      ov_r      <= 1'b0;
      used_r    <= '0;
      next_id_r <= 32'd1;
      for (int i = 0; i < PORTS; i++) begin
        port_r[i] <= '0; owner_r[i] <= '0; head_r[i] <= '0; tail_r[i] <= '0;
        count_r[i] <= '0; isnd_r[i] <= '0; ilen_r[i] <= '0; idat_r[i] <= '0;
        icnt_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      if (st_r == BK_EXEC) begin
        ov_r <= 1'b1;
        priority case (1'b1)
          req_r.func == FN_CREATE && free_ok_r: begin
            used_r[slot_r] <= 1'b1; port_r[slot_r] <= next_id_r;
            owner_r[slot_r] <= req_r.task_id; head_r[slot_r] <= '0;
            tail_r[slot_r] <= '0; count_r[slot_r] <= '0; isnd_r[slot_r] <= '0;
            ilen_r[slot_r] <= '0; idat_r[slot_r] <= '0; icnt_r[slot_r] <= '0;
            next_id_r <= (next_id_r == 32'hffff_ffff) ? 32'd1 : next_id_r + 32'd1;
          end
          req_r.func == FN_DESTROY && hit_r: begin
            used_r[slot_r] <= 1'b0; port_r[slot_r] <= '0; owner_r[slot_r] <= '0;
            head_r[slot_r] <= '0; tail_r[slot_r] <= '0; count_r[slot_r] <= '0;
            isnd_r[slot_r] <= '0; ilen_r[slot_r] <= '0; idat_r[slot_r] <= '0;
            icnt_r[slot_r] <= '0;
          end
          we: begin
            tail_r[slot_r] <= (tail_r[slot_r] == QW'(QUEUE_DEPTH - 1)) ? '0
                              : tail_r[slot_r] + QW'(1);
            count_r[slot_r] <= count_r[slot_r] + CW'(1);
          end
          (req_r.func == FN_TRY_SEND) && hit_r && !len_bad && full_c &&
            ilen_r[slot_r] != 4'd0: begin
            if (icnt_r[slot_r] != 32'hffff_ffff) icnt_r[slot_r] <= icnt_r[slot_r] + 32'd1;
          end
          req_r.func == FN_RECEIVE && hit_r && req_r.capacity != 4'd0: begin
            if (count_r[slot_r] != '0) begin
              head_r[slot_r] <= (head_r[slot_r] == QW'(QUEUE_DEPTH - 1)) ? '0
                                : head_r[slot_r] + QW'(1);
              count_r[slot_r] <= count_r[slot_r] - CW'(1);
            end else if (ilen_r[slot_r] != 4'd0 && icnt_r[slot_r] != 32'd0)
              icnt_r[slot_r] <= icnt_r[slot_r] - 32'd1;
          end
          req_r.func == FN_CFG_IRQ && hit_r && !len_bad: begin
            isnd_r[slot_r] <= req_r.sender; ilen_r[slot_r] <= req_r.length;
            idat_r[slot_r] <= req_r.payload & byte_mask(req_r.length);
            icnt_r[slot_r] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == BK_IDLE) else $error("word taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_EXEC) |=> ov_r) else $error("result not presented");
  a_next_nz: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != 32'd0) else $error("port id zero");

endmodule

FILE: src/multi_port_message_mailbox.sv
// An accepted word passes through the two-entry queue and then the back-end
// sequencer (lookup, message memory read, execute, deliver) to its result word;
// the sequencer handles one word at a time, and the output can stall it.
// A two-entry queue lets input accept words while the back end works.
// Reset (synchronous, active low) empties all ports; port ids restart at one.
module multi_port_message_mailbox #(
  parameter int PORTS         = 8,
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mpmm_req_if.sink    in_ch,
  mpmm_rsp_if.source  out_ch
);
  import mpmm_pkg::*;

  req_t q_data;
  logic q_valid, q_pop;

  mpmm_front u_front (
    .clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop
  );

  mpmm_back #(
    .PORTS(PORTS), .QUEUE_DEPTH(QUEUE_DEPTH), .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop, .out_ch
  );

endmodule
